FILE: rtl/nnti_pkg.sv
`timescale 1ns / 1ps

package nnti_pkg;

  // Default sizing
  localparam int unsigned MAX_TARGETS_DEFAULT = 16;
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // Fixed field widths
  localparam int unsigned GATE_W    = 15;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Register reset values
  localparam logic [GATE_W-1:0] GATE_RESET = 15'd300;
  localparam logic [AGE_W-1:0]  AGE_RESET  = 16'd500;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_GATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE    = 1'b1;

  // Input word kinds
  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_DETECT = 1'b1;

  // Identity range
  localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
  localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic frame_load;
    logic det_load;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
  } dp_status_t;

endpackage

FILE: rtl/nnti_ctrl.sv
`timescale 1ns / 1ps

module nnti_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   mode,
  input  nnti_pkg::dp_status_t   status,
  output logic                   busy,
  output nnti_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == nnti_pkg::MODE_DETECT) begin
            cmd.det_load = 1'b1;
            state_next   = ST_SCAN;
          end else begin
            cmd.frame_load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.issue_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/nnti_dp.sv
`timescale 1ns / 1ps

module nnti_dp #(
  parameter int unsigned MAX_TARGETS = nnti_pkg::MAX_TARGETS_DEFAULT,
  parameter int unsigned COORD_WIDTH = nnti_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nnti_pkg::ctrl_cmd_t                   cmd,
  output nnti_pkg::dp_status_t                  status,
  input  logic                                  cfg_write,
  input  logic [nnti_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nnti_pkg::CFG_W-1:0]            cfg_data,
  input  logic [nnti_pkg::TIME_W-1:0]           time_ms,
  input  logic signed [COORD_WIDTH-1:0]         pos_x,
  input  logic signed [COORD_WIDTH-1:0]         pos_y,
  output logic                                  done,
  output logic [nnti_pkg::ID_W-1:0]             target_id,
  output logic                                  is_new,
  output logic                                  not_stored
);

  localparam int unsigned IDX_W = $clog2(MAX_TARGETS);
  localparam int unsigned CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int unsigned AW    = $clog2(2 * MAX_TARGETS);
  localparam int unsigned ID_W  = nnti_pkg::ID_W;
  localparam int unsigned MW    = 2 * COORD_WIDTH + ID_W;
  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned GW    = nnti_pkg::GATE_W;
  localparam int unsigned CMPW  = (DW > GW) ? DW : GW;
  localparam int unsigned SQ_W  = 2 * GW;
  localparam int unsigned D2_W  = SQ_W + 1;
  localparam int unsigned TW    = nnti_pkg::TIME_W;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TARGETS);
  localparam logic [AW-1:0]    BANK_OFS = AW'(MAX_TARGETS);

  // Configuration
  logic [GW-1:0]                  match_gate;
  logic [nnti_pkg::AGE_W-1:0]     max_age;

  // Frame and table state
  logic [TW-1:0]                  last_frame_time;
  logic [CNT_W-1:0]               ref_count;
  logic [CNT_W-1:0]               fill_count;
  logic                           bank_select;
  logic [MAX_TARGETS-1:0]         claimed;
  logic [ID_W-1:0]                next_ident;

  // Current detection and best match
  logic signed [COORD_WIDTH-1:0]  det_x;
  logic signed [COORD_WIDTH-1:0]  det_y;
  logic [CNT_W-1:0]               scan_idx;
  logic [D2_W-1:0]                best_d2;
  logic [IDX_W-1:0]               win_slot;
  logic [ID_W-1:0]                best_ident;
  logic                           found;

  // Table memory, two banks
  logic [MW-1:0]                  table_mem [2*MAX_TARGETS];
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic                           has_room;

  // Scan pipeline
  logic                           va;
  logic [IDX_W-1:0]               ia;
  logic [MW-1:0]                  rd_word;
  logic                           vb;
  logic [IDX_W-1:0]               ib;
  logic [ID_W-1:0]                idb;
  logic                           okb;
  logic [GW-1:0]                  dxb;
  logic [GW-1:0]                  dyb;
  logic                           vc;
  logic [IDX_W-1:0]               ic;
  logic [ID_W-1:0]                idc;
  logic                           okc;
  logic [SQ_W-1:0]                sqx;
  logic [SQ_W-1:0]                sqy;

  // Combinational terms
  logic [TW-1:0]                  gap;
  logic [COORD_WIDTH-1:0]         tx;
  logic [COORD_WIDTH-1:0]         ty;
  logic [ID_W-1:0]                tid;
  logic [DW-1:0]                  diff_x;
  logic [DW-1:0]                  diff_y;
  logic [DW-1:0]                  abs_x;
  logic [DW-1:0]                  abs_y;
  logic [CMPW-1:0]                ext_x;
  logic [CMPW-1:0]                ext_y;
  logic [CMPW-1:0]                gate_ext;
  logic                           entry_ok;
  logic [D2_W-1:0]                d2;
  logic                           better;
  logic [ID_W-1:0]                ident_sel;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      match_gate <= nnti_pkg::GATE_RESET;
      max_age    <= nnti_pkg::AGE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == nnti_pkg::REG_MATCH_GATE) begin
        match_gate <= cfg_data[GW-1:0];
      end else if (cfg_index == nnti_pkg::REG_MAX_AGE) begin
        max_age <= cfg_data[nnti_pkg::AGE_W-1:0];
      end
    end
  end

  // Addresses: reference bank is the one not being filled
  assign gap      = time_ms - last_frame_time;
  assign rd_addr  = (bank_select ? '0 : BANK_OFS) + AW'(scan_idx[IDX_W-1:0]);
  assign wr_addr  = (bank_select ? BANK_OFS : '0) + AW'(fill_count[IDX_W-1:0]);
  assign has_room = (fill_count < CNT_MAX);

  // Stage B: distance components and gate test
  assign tx     = rd_word[MW-1 -: COORD_WIDTH];
  assign ty     = rd_word[ID_W +: COORD_WIDTH];
  assign tid    = rd_word[ID_W-1:0];
  assign diff_x = {det_x[COORD_WIDTH-1], det_x} - {tx[COORD_WIDTH-1], tx};
  assign diff_y = {det_y[COORD_WIDTH-1], det_y} - {ty[COORD_WIDTH-1], ty};
  assign abs_x  = diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
  assign abs_y  = diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;
  assign ext_x    = CMPW'(abs_x);
  assign ext_y    = CMPW'(abs_y);
  assign gate_ext = CMPW'(match_gate);
  assign entry_ok = !claimed[ia] && (ext_x <= gate_ext) && (ext_y <= gate_ext);

  // Stage D: squared distance against best so far (strict, first wins ties)
  assign d2     = D2_W'(sqx) + D2_W'(sqy);
  assign better = vc && okc && (d2 < best_d2);

  assign ident_sel = found ? best_ident : next_ident;

  assign status.issue_done = (scan_idx == ref_count);
  assign status.pipe_empty = !(va || vb || vc);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_time <= '0;
      ref_count       <= '0;
      fill_count      <= '0;
      bank_select     <= 1'b0;
      claimed         <= '0;
      next_ident      <= nnti_pkg::ID_FIRST;
      scan_idx        <= '0;
      found           <= 1'b0;
      va              <= 1'b0;
      vb              <= 1'b0;
      vc              <= 1'b0;
      done            <= 1'b0;
    end else begin
      va   <= cmd.issue;
      vb   <= va;
      vc   <= vb;
      done <= cmd.commit;
      if (cmd.frame_load) begin
        ref_count       <= (gap >= TW'(max_age)) ? '0 : fill_count;
        bank_select     <= ~bank_select;
        fill_count      <= '0;
        claimed         <= '0;
        last_frame_time <= time_ms;
      end
      if (cmd.det_load) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end
      if (cmd.issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (better) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        if (found) begin
          claimed[win_slot] <= 1'b1;
        end else begin
          next_ident <= (next_ident == nnti_pkg::ID_LAST) ? nnti_pkg::ID_FIRST
                                                          : next_ident + ID_W'(1);
        end
        if (has_room) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && has_room) begin
      table_mem[wr_addr] <= {det_x, det_y, ident_sel};
    end
    rd_word <= table_mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.det_load) begin
      det_x   <= pos_x;
      det_y   <= pos_y;
      best_d2 <= D2_W'(match_gate) * D2_W'(match_gate);
    end else if (better) begin
      best_d2    <= d2;
      win_slot   <= ic;
      best_ident <= idc;
    end
    ia  <= scan_idx[IDX_W-1:0];
    ib  <= ia;
    idb <= tid;
    okb <= entry_ok;
    dxb <= ext_x[GW-1:0];
    dyb <= ext_y[GW-1:0];
    ic  <= ib;
    idc <= idb;
    okc <= okb;
    sqx <= SQ_W'(dxb) * SQ_W'(dxb);
    sqy <= SQ_W'(dyb) * SQ_W'(dyb);
    if (cmd.commit) begin
      target_id  <= ident_sel;
      is_new     <= !found;
      not_stored <= !has_room;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && has_room) |=> (fill_count == $past(fill_count) + CNT_W'(1)))
    else $error("fill count did not advance on a stored word");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (target_id != '0))
    else $error("result word carries identity zero");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (scan_idx < ref_count))
    else $error("scan read past the reference table");

  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(va || vb || vc))
    else $error("commit while scan pipeline still busy");
`endif

endmodule

FILE: rtl/nearest_neighbour_track_id_top.sv
`timescale 1ns / 1ps

// Greedy nearest-neighbour track identity assignment.
// Input words: accepted on a clock edge with start high and busy low.
//   mode = frame start: time_ms is used; the previous frame's detections
//     become the reference table (emptied if the gap reaches max_age_ms).
//     Busy stays low, no result word.
//   mode = detection: pos_x/pos_y are matched against the reference table.
// Result words: done is high for exactly one cycle with target_id, is_new
//   and not_stored; the receiver must take it, there is no back-pressure.
// Scan: with n reference entries (n <= MAX_TARGETS), the table memory is
//   read one entry per cycle through a four-stage distance pipeline; busy
//   falls with done.
// Config port: cfg_write with cfg_index 0 (match gate, mm) or 1 (max age,
//   ms) and cfg_data; write only while busy is low and no word in flight.
// Reset (rst, synchronous): gate 300, age 500, tables empty, next identity
//   1, last frame time 0. No memory clearing pass is needed.
module nearest_neighbour_track_id_top #(
  parameter int unsigned MAX_TARGETS = nnti_pkg::MAX_TARGETS_DEFAULT,
  parameter int unsigned COORD_WIDTH = nnti_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode,
  input  logic [nnti_pkg::TIME_W-1:0]        time_ms,
  input  logic signed [COORD_WIDTH-1:0]      pos_x,
  input  logic signed [COORD_WIDTH-1:0]      pos_y,
  input  logic                               cfg_write,
  input  logic [nnti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnti_pkg::CFG_W-1:0]         cfg_data,
  output logic                               done,
  output logic [nnti_pkg::ID_W-1:0]          target_id,
  output logic                               is_new,
  output logic                               not_stored
);

  nnti_pkg::ctrl_cmd_t  cmd;
  nnti_pkg::dp_status_t status;

  // Sequencer
  nnti_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Table, distance pipeline and identity logic
  nnti_dp #(
    .MAX_TARGETS (MAX_TARGETS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .time_ms    (time_ms),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .done       (done),
    .target_id  (target_id),
    .is_new     (is_new),
    .not_stored (not_stored)
  );

endmodule

FILE: tb/nnti_track_checker.sv
`timescale 1ns / 1ps

module nnti_track_checker #(
  parameter int unsigned MAX_TARGETS = nnti_pkg::MAX_TARGETS_DEFAULT,
  parameter int unsigned COORD_WIDTH = nnti_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               mode,
  input  logic [nnti_pkg::TIME_W-1:0]        time_ms,
  input  logic signed [COORD_WIDTH-1:0]      pos_x,
  input  logic signed [COORD_WIDTH-1:0]      pos_y,
  input  logic                               cfg_write,
  input  logic [nnti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnti_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               done,
  input  logic [nnti_pkg::ID_W-1:0]          target_id,
  input  logic                               is_new,
  input  logic                               not_stored,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 checked
);

  typedef struct {
    logic [nnti_pkg::ID_W-1:0] ident;
    logic                      fresh;
    logic                      dropped;
  } id_word_t;

  // Shadow of the track tables: two banks, one filling, one reference
  logic signed [COORD_WIDTH-1:0] bank_x [2*MAX_TARGETS];
  logic signed [COORD_WIDTH-1:0] bank_y [2*MAX_TARGETS];
  logic [nnti_pkg::ID_W-1:0]     bank_id [2*MAX_TARGETS];
  bit                            taken [MAX_TARGETS];
  int unsigned                   live_refs;
  int unsigned                   fill_cnt;
  bit                            fill_bank;
  logic [nnti_pkg::ID_W-1:0]     next_fresh_id;
  logic [nnti_pkg::TIME_W-1:0]   prev_frame_ms;
  logic [nnti_pkg::GATE_W-1:0]   gate_mm;
  logic [nnti_pkg::AGE_W-1:0]    age_ms;

  id_word_t expected_ids[$];

  // Frame start: last frame's detections become the reference, or are aged out
  function automatic void rotate_tables(input logic [nnti_pkg::TIME_W-1:0] now);
    logic [nnti_pkg::TIME_W-1:0] gap;
    gap = now - prev_frame_ms;
    live_refs = (gap >= age_ms) ? 0 : fill_cnt;
    fill_bank = ~fill_bank;
    fill_cnt = 0;
    foreach (taken[j]) taken[j] = 1'b0;
    prev_frame_ms = now;
  endfunction

  // Greedy match against unclaimed reference entries, then store in fill bank
  function automatic id_word_t assign_identity(input logic signed [COORD_WIDTH-1:0] px,
                                               input logic signed [COORD_WIDTH-1:0] py);
    longint      dx, dy, d2, lim, best;
    int unsigned ref_base, best_slot, slot;
    bit          hit;
    id_word_t    w;
    lim = longint'(gate_mm);
    best = lim * lim;
    hit = 1'b0;
    best_slot = 0;
    ref_base = fill_bank ? 0 : MAX_TARGETS;
    for (int j = 0; j < MAX_TARGETS; j++) begin
      if (j < live_refs && !taken[j]) begin
        dx = longint'(px) - longint'(bank_x[ref_base + j]);
        dy = longint'(py) - longint'(bank_y[ref_base + j]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx <= lim && dy <= lim) begin
          d2 = dx * dx + dy * dy;
          if (d2 < best) begin
            best = d2;
            best_slot = j;
            hit = 1'b1;
          end
        end
      end
    end
    if (hit) begin
      w.ident = bank_id[ref_base + best_slot];
      w.fresh = 1'b0;
      taken[best_slot] = 1'b1;
    end else begin
      w.ident = next_fresh_id;
      w.fresh = 1'b1;
      next_fresh_id = (next_fresh_id == nnti_pkg::ID_LAST) ? nnti_pkg::ID_FIRST
                                                            : next_fresh_id + 16'd1;
    end
    if (fill_cnt < MAX_TARGETS) begin
      slot = (fill_bank ? MAX_TARGETS : 0) + fill_cnt;
      bank_x[slot] = px;
      bank_y[slot] = py;
      bank_id[slot] = w.ident;
      fill_cnt++;
      w.dropped = 1'b0;
    end else begin
      w.dropped = 1'b1;
    end
    return w;
  endfunction

  // Result words first, then config writes, then newly accepted words
  always @(posedge clk) begin : watch
    id_word_t want;
    if (rst) begin
      expected_ids.delete();
      foreach (taken[j]) taken[j] = 1'b0;
      live_refs = 0;
      fill_cnt = 0;
      fill_bank = 1'b0;
      next_fresh_id = nnti_pkg::ID_FIRST;
      prev_frame_ms = '0;
      gate_mm = nnti_pkg::GATE_RESET;
      age_ms = nnti_pkg::AGE_RESET;
      mismatches = 0;
      checked = 0;
    end else begin
      if (done) begin
        if (expected_ids.size() == 0) begin
          $display("%0t: unexpected result word: target_id %0d is_new %0b not_stored %0b",
                   $time, target_id, is_new, not_stored);
          mismatches++;
        end else begin
          want = expected_ids.pop_front();
          checked++;
          if (target_id !== want.ident) begin
            $display("%0t: target_id expected %0d actual %0d", $time, want.ident, target_id);
            mismatches++;
          end
          if (is_new !== want.fresh) begin
            $display("%0t: is_new expected %0b actual %0b", $time, want.fresh, is_new);
            mismatches++;
          end
          if (not_stored !== want.dropped) begin
            $display("%0t: not_stored expected %0b actual %0b", $time, want.dropped,
                     not_stored);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          nnti_pkg::REG_MATCH_GATE: gate_mm = cfg_data[nnti_pkg::GATE_W-1:0];
          nnti_pkg::REG_MAX_AGE:    age_ms = cfg_data[nnti_pkg::AGE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (mode == nnti_pkg::MODE_FRAME) rotate_tables(time_ms);
        else expected_ids.insert(expected_ids.size(), assign_identity(pos_x, pos_y));
      end
    end
    pending = expected_ids.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MT          = 16;
  localparam int CW          = 16;
  localparam int MAX_TRK     = 20;
  localparam int PHASE_WORDS = 150;
  localparam int CYCLE_LIMIT = 800000;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 mode = nnti_pkg::MODE_FRAME;
  logic [nnti_pkg::TIME_W-1:0]          time_ms = '0;
  logic signed [CW-1:0]                 pos_x = '0;
  logic signed [CW-1:0]                 pos_y = '0;
  logic                                 cfg_write = 1'b0;
  logic [nnti_pkg::CFG_IDX_W-1:0]       cfg_index = nnti_pkg::REG_MATCH_GATE;
  logic [nnti_pkg::CFG_W-1:0]           cfg_data = '0;
  logic                                 busy;
  logic                                 done;
  logic [nnti_pkg::ID_W-1:0]            target_id;
  logic                                 is_new;
  logic                                 not_stored;
  int                                   mismatches;
  int                                   pending;
  int                                   checked;

  // Stimulus bookkeeping
  int                                   cycles = 0;
  int                                   n_frames = 0;
  int                                   n_dets = 0;
  bit                                   idle_on = 1'b1;
  int                                   cur_gate = 300;
  int                                   cur_age = 500;
  logic [nnti_pkg::TIME_W-1:0]          clock_ms = '0;
  int                                   trk_n = 0;
  int                                   trk_x [MAX_TRK];
  int                                   trk_y [MAX_TRK];
  int                                   trk_vx [MAX_TRK];
  int                                   trk_vy [MAX_TRK];

  always #4 clk = ~clk;

  nearest_neighbour_track_id_top #(.MAX_TARGETS(MT), .COORD_WIDTH(CW)) dut (.*);

  nnti_track_checker #(.MAX_TARGETS(MT), .COORD_WIDTH(CW)) track_check (.*);

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Drive one word at the falling edge and hold it until accepted
  task automatic push_word(input logic m, input logic [nnti_pkg::TIME_W-1:0] t, input int x,
                           input int y);
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    time_ms <= t;
    pos_x <= 16'(x);
    pos_y <= 16'(y);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == nnti_pkg::MODE_FRAME) n_frames++;
    else n_dets++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk);
    end
  endtask

  // Drop start and wait for every outstanding word to drain
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nnti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nnti_pkg::CFG_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_gate(input int g);
    write_reg(nnti_pkg::REG_MATCH_GATE, {1'($urandom), 15'(g)});
    cur_gate = g;
  endtask

  task automatic set_age(input int a);
    write_reg(nnti_pkg::REG_MAX_AGE, 16'(a));
    cur_age = a;
  endtask

  // One frame of moving tracks with jitter, churn and occasional clutter
  task automatic send_frame();
    int step_sel, want, jit, first, k, x, y;
    step_sel = $urandom_range(0, 19);
    if (step_sel == 0) clock_ms += cur_age + $urandom_range(0, 50);
    else if (step_sel == 1) clock_ms = $urandom;
    else if (step_sel == 2 && cur_age > 0) clock_ms += cur_age - 1;
    else if (step_sel == 3) clock_ms += 0;
    else clock_ms += $urandom_range(25, 45);
    push_word(nnti_pkg::MODE_FRAME, clock_ms, any_coord(), any_coord());

    // track loss and birth; now and then a crowd that overfills the table
    if (trk_n > 0 && $urandom_range(0, 11) == 0) begin
      k = $urandom_range(0, trk_n - 1);
      trk_n--;
      trk_x[k] = trk_x[trk_n];
      trk_y[k] = trk_y[trk_n];
      trk_vx[k] = trk_vx[trk_n];
      trk_vy[k] = trk_vy[trk_n];
    end
    want = ($urandom_range(0, 14) == 0) ? MAX_TRK : trk_n + ($urandom_range(0, 3) == 0);
    if (want > MAX_TRK) want = MAX_TRK;
    while (trk_n < want) begin
      if ($urandom_range(0, 5) == 0) begin
        trk_x[trk_n] = $urandom_range(0, 1) ? 32767 : -32768;
        trk_y[trk_n] = $urandom_range(0, 1) ? 32767 : -32768;
      end else begin
        trk_x[trk_n] = any_coord();
        trk_y[trk_n] = any_coord();
      end
      trk_vx[trk_n] = int'($urandom_range(0, 40)) - 20;
      trk_vy[trk_n] = int'($urandom_range(0, 40)) - 20;
      trk_n++;
    end

    jit = cur_gate / 4;
    if (jit > 200) jit = 200;
    first = (trk_n > 0) ? $urandom_range(0, trk_n - 1) : 0;
    for (int i = 0; i < trk_n; i++) begin
      k = (first + i) % trk_n;
      trk_x[k] = clip16(trk_x[k] + trk_vx[k]);
      trk_y[k] = clip16(trk_y[k] + trk_vy[k]);
      if ($urandom_range(0, 9) != 0) begin
        x = clip16(trk_x[k] + int'($urandom_range(0, 2 * jit)) - jit);
        y = clip16(trk_y[k] + int'($urandom_range(0, 2 * jit)) - jit);
        push_word(nnti_pkg::MODE_DETECT, $urandom, x, y);
      end
      if ($urandom_range(0, 7) == 0) begin
        push_word(nnti_pkg::MODE_DETECT, $urandom, any_coord(), any_coord());
      end
    end
  endtask

  initial begin
    int mark;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: detections before any frame, coordinate extremes
    push_word(nnti_pkg::MODE_DETECT, 32'hFFFF_FFFF, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 32767, 32767);
    push_word(nnti_pkg::MODE_DETECT, 32'h5555_5555, -32768, -32768);
    // gap under max age keeps the table; gate edge is exclusive; claims hold
    push_word(nnti_pkg::MODE_FRAME, 100, -1, -1);
    push_word(nnti_pkg::MODE_DETECT, 0, 10, 10);
    push_word(nnti_pkg::MODE_DETECT, 0, -32768, -32768 + 299);
    push_word(nnti_pkg::MODE_DETECT, 0, 32767 - 300, 32767);
    push_word(nnti_pkg::MODE_DETECT, 0, 0, 0);
    // gap equal to max age forgets
    push_word(nnti_pkg::MODE_FRAME, 600, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 5, 5);
    push_word(nnti_pkg::MODE_FRAME, 32'hFFFF_FF00, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 1, 1);
    // time wraps past zero with a small gap
    push_word(nnti_pkg::MODE_FRAME, 32'h0000_0010, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 1, 2);
    // equal distances: first table entry wins, then the other
    push_word(nnti_pkg::MODE_FRAME, 32'h0000_03F8, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 100, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, -100, 0);
    push_word(nnti_pkg::MODE_FRAME, 32'h0000_0419, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 0, 0);
    push_word(nnti_pkg::MODE_DETECT, 0, 0, 0);
    clock_ms = 32'h0000_0419;

    // Random phases over several register settings, extremes included
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        idle_on = 1'b0;
      end
      case (p)
        0: begin set_gate(32767); set_age(65535); end
        1: begin set_gate(1); set_age(1); end
        2: begin set_gate(0); set_age(0); end
        3: begin set_gate($urandom_range(100, 3000)); set_age($urandom_range(40, 800)); end
        4: begin set_gate($urandom_range(1, 32767)); set_age($urandom_range(1, 65535)); end
        default: begin set_gate($urandom_range(50, 2000)); set_age($urandom_range(60, 2000)); end
      endcase
      mark = n_frames + n_dets;
      while (n_frames + n_dets - mark < PHASE_WORDS) send_frame();
    end

    drain();
    $display("tb: %0d frame starts and %0d detections sent, %0d result words checked",
             n_frames, n_dets, checked);
    $display("tb: six gate/age settings incl. zero and full scale, table overflow, time wrap");
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
